/* rtl/slc_pkg.sv */
// slc_pkg: types, codes and constants shared by the shell command lexer.
// No dependencies; imported by every module of the block.
package slc_pkg;

  // Configuration
  localparam int            MAX_TOKENS_DEF = 256;
  localparam int            CAP_W          = 9;
  localparam logic [CAP_W-1:0] CAP_RESET   = 9'd32;
  localparam int            ADDR_W         = 3;
  localparam int            DATA_W         = 32;
  localparam logic          REG_TOKEN_CAPACITY = 1'b0;

  // Result queue depth
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_BAR    = 8'h7c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  typedef enum logic [3:0] {
    KIND_BYTE         = 4'd0,
    KIND_WORD_END     = 4'd1,
    KIND_NEWLINE      = 4'd2,
    KIND_PIPE         = 4'd3,
    KIND_OR_OR        = 4'd4,
    KIND_AND_AND      = 4'd5,
    KIND_REDIR_OUT    = 4'd6,
    KIND_REDIR_APPEND = 4'd7,
    KIND_REDIR_IN     = 4'd8,
    KIND_SEMI         = 4'd9,
    KIND_EOF          = 4'd10
  } token_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_EXHAUSTED   = 2'd1,
    ERR_OPEN_SINGLE = 2'd2,
    ERR_OPEN_DOUBLE = 2'd3
  } error_code_t;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_BAR,
    MODE_AMP,
    MODE_GT,
    MODE_WORD,
    MODE_SQ,
    MODE_DQ,
    MODE_DISCARD
  } lex_mode_t;

  typedef struct packed {
    token_kind_t kind;
    logic [7:0]  data;
    logic        sq;
    logic        dq;
    error_code_t err;
    logic        last;
  } result_t;

  // Up to two results per input transaction
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

endpackage

/* rtl/shell_command_lexer.sv */
// shell_command_lexer: top level with the capacity register (APB) and the
// lexer core feeding a four-entry result queue. Depends on slc_pkg,
// slc_lexer and slc_result_fifo.
// An accepted byte's results are registered into the queue, whose head drives the output.
// Throughput: one byte per cycle while in_ready is high; a byte that closes a token and
// starts another can give two results, and the output drains at one per cycle while out_ready is high.
// The queue admits a byte while it holds two or fewer results.
// Reset (synchronous, rst high) empties the queue, returns the lexer to
// between tokens with zero count, and sets token_capacity to 32.
module shell_command_lexer #(
  parameter int MAX_TOKENS = slc_pkg::MAX_TOKENS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  char_in,
  input  logic                        end_of_input,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [3:0]                  token_kind,
  output logic [7:0]                  word_byte,
  output logic                        single_quoted,
  output logic                        double_quoted,
  output logic [1:0]                  error_code,
  output logic                        last_of_run,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [slc_pkg::ADDR_W-1:0]  paddr,
  input  logic [slc_pkg::DATA_W-1:0]  pwdata,
  output logic [slc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import slc_pkg::*;

  logic [CAP_W-1:0] token_capacity;
  logic             reg_index;
  logic             accept;
  result_pair_t     push;
  result_t          head;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign prdata    = (reg_index == REG_TOKEN_CAPACITY) ?
                     DATA_W'(token_capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      token_capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready &&
                 reg_index == REG_TOKEN_CAPACITY) begin
      token_capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign accept = in_valid && in_ready;

  slc_lexer #(
    .MAX_TOKENS(MAX_TOKENS)
  ) u_lexer (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .char_in        (char_in),
    .end_of_input   (end_of_input),
    .token_capacity (token_capacity),
    .push           (push)
  );

  slc_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space_ok  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign token_kind    = head.kind;
  assign word_byte     = head.data;
  assign single_quoted = head.sq;
  assign double_quoted = head.dq;
  assign error_code    = head.err;
  assign last_of_run   = head.last;

endmodule

/* rtl/slc_lexer.sv */
// slc_lexer: lexer state and the single-pass decode of one input byte into
// up to two results. Depends on slc_pkg.
module slc_lexer #(
  parameter int MAX_TOKENS = slc_pkg::MAX_TOKENS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [7:0]                  char_in,
  input  logic                        end_of_input,
  input  logic [slc_pkg::CAP_W-1:0]   token_capacity,
  output slc_pkg::result_pair_t       push
);
  import slc_pkg::*;

  localparam int LW = ($clog2(MAX_TOKENS + 1) > CAP_W) ? $clog2(MAX_TOKENS + 1) : CAP_W;

  lex_mode_t   mode, mode_next;
  logic        has_text, has_text_next;
  logic        sq_flag, sq_flag_next;
  logic        dq_flag, dq_flag_next;
  logic [LW-1:0] tokens_emitted, tokens_emitted_next;

  // Fresh-token decode of the byte
  logic        f_emit, f_text, f_sq, f_dq;
  token_kind_t f_kind;
  lex_mode_t   f_mode;
  logic        is_sep;

  // First phase: operator/word closing or word byte
  logic        a_req, a_sq, a_dq, a_put;
  token_kind_t a_kind, a_put_kind;
  error_code_t a_put_err;
  logic [7:0]  a_put_data;
  logic        b_fresh, b_eof;
  lex_mode_t   mode_a;
  logic        text_a, sq_a, dq_a;

  logic [LW-1:0] cap_ext, lim, cnt_a;
  logic        a_refused, b_run_fresh, b_run_eof, b_req, b_put, b_refused;
  token_kind_t b_kind;
  logic        a_any, b_any;
  result_t     ra, rb;

  always_comb begin
    f_emit = 1'b0;
    f_text = 1'b0;
    f_sq   = 1'b0;
    f_dq   = 1'b0;
    f_kind = KIND_NEWLINE;
    f_mode = MODE_IDLE;
    is_sep = 1'b1;
    case (char_in) inside
      CH_SPACE, CH_TAB, CH_CR: begin
      end
      CH_LF: begin
        f_emit = 1'b1;
        f_kind = KIND_NEWLINE;
      end
      CH_BAR:  f_mode = MODE_BAR;
      CH_AMP:  f_mode = MODE_AMP;
      CH_GT:   f_mode = MODE_GT;
      CH_LT: begin
        f_emit = 1'b1;
        f_kind = KIND_REDIR_IN;
      end
      CH_SEMI: begin
        f_emit = 1'b1;
        f_kind = KIND_SEMI;
      end
      CH_SQUOTE: begin
        is_sep = 1'b0;
        f_sq   = 1'b1;
        f_mode = MODE_SQ;
      end
      CH_DQUOTE: begin
        is_sep = 1'b0;
        f_dq   = 1'b1;
        f_mode = MODE_DQ;
      end
      default: begin
        is_sep = 1'b0;
        f_text = 1'b1;
        f_mode = MODE_WORD;
      end
    endcase
  end

  always_comb begin
    a_req      = 1'b0;
    a_kind     = KIND_PIPE;
    a_sq       = 1'b0;
    a_dq       = 1'b0;
    a_put      = 1'b0;
    a_put_kind = KIND_BYTE;
    a_put_err  = ERR_NONE;
    a_put_data = char_in;
    b_fresh    = 1'b0;
    b_eof      = 1'b0;
    mode_a     = mode;
    text_a     = has_text;
    sq_a       = sq_flag;
    dq_a       = dq_flag;
    if (end_of_input) begin
      a_put_data = 8'h00;
      unique case (mode)
        MODE_DISCARD: begin
        end
        MODE_BAR: begin
          a_req  = 1'b1;
          a_kind = KIND_PIPE;
          b_eof  = 1'b1;
        end
        MODE_GT: begin
          a_req  = 1'b1;
          a_kind = KIND_REDIR_OUT;
          b_eof  = 1'b1;
        end
        MODE_WORD: begin
          a_req  = has_text;
          a_kind = KIND_WORD_END;
          a_sq   = sq_flag;
          a_dq   = dq_flag;
          b_eof  = 1'b1;
        end
        MODE_SQ: begin
          a_put      = 1'b1;
          a_put_kind = KIND_EOF;
          a_put_err  = ERR_OPEN_SINGLE;
        end
        MODE_DQ: begin
          a_put      = 1'b1;
          a_put_kind = KIND_EOF;
          a_put_err  = ERR_OPEN_DOUBLE;
        end
        MODE_IDLE, MODE_AMP: b_eof = 1'b1;
      endcase
    end else begin
      unique case (mode)
        MODE_DISCARD: begin
        end
        MODE_BAR: begin
          mode_a = MODE_IDLE;
          a_req  = 1'b1;
          if (char_in == CH_BAR) begin
            a_kind = KIND_OR_OR;
          end else begin
            a_kind  = KIND_PIPE;
            b_fresh = 1'b1;
          end
        end
        MODE_AMP: begin
          mode_a = MODE_IDLE;
          if (char_in == CH_AMP) begin
            a_req  = 1'b1;
            a_kind = KIND_AND_AND;
          end else begin
            b_fresh = 1'b1;  // lone ampersand is dropped
          end
        end
        MODE_GT: begin
          mode_a = MODE_IDLE;
          a_req  = 1'b1;
          if (char_in == CH_GT) begin
            a_kind = KIND_REDIR_APPEND;
          end else begin
            a_kind  = KIND_REDIR_OUT;
            b_fresh = 1'b1;
          end
        end
        MODE_WORD: begin
          if (is_sep) begin
            mode_a = MODE_IDLE;
            text_a = 1'b0;
            sq_a   = 1'b0;
            dq_a   = 1'b0;
            // A word of only empty quotes swallows its delimiter
            if (has_text) begin
              a_req   = 1'b1;
              a_kind  = KIND_WORD_END;
              a_sq    = sq_flag;
              a_dq    = dq_flag;
              b_fresh = 1'b1;
            end
          end else if (char_in == CH_SQUOTE) begin
            sq_a   = 1'b1;
            mode_a = MODE_SQ;
          end else if (char_in == CH_DQUOTE) begin
            dq_a   = 1'b1;
            mode_a = MODE_DQ;
          end else begin
            text_a = 1'b1;
            a_put  = 1'b1;
          end
        end
        MODE_SQ: begin
          if (char_in == CH_SQUOTE) begin
            mode_a = MODE_WORD;
          end else begin
            text_a = 1'b1;
            a_put  = 1'b1;
          end
        end
        MODE_DQ: begin
          if (char_in == CH_DQUOTE) begin
            mode_a = MODE_WORD;
          end else begin
            text_a = 1'b1;
            a_put  = 1'b1;
          end
        end
        MODE_IDLE: b_fresh = 1'b1;
      endcase
    end
  end

  // Capacity checks for the two counted tokens one byte can produce
  always_comb begin
    cap_ext     = LW'(token_capacity);
    lim         = (cap_ext > LW'(MAX_TOKENS)) ? LW'(MAX_TOKENS) : cap_ext;
    a_refused   = a_req && (tokens_emitted >= lim);
    cnt_a       = tokens_emitted + LW'(a_req && !a_refused);
    b_run_fresh = b_fresh && !a_refused;
    b_run_eof   = b_eof && !a_refused;
    b_req       = b_run_eof || (b_run_fresh && f_emit);
    b_kind      = b_run_eof ? KIND_EOF : f_kind;
    b_put       = b_run_fresh && f_text;
    b_refused   = b_req && (cnt_a >= lim);
  end

  // Next state
  always_comb begin
    mode_next           = mode_a;
    has_text_next       = text_a;
    sq_flag_next        = sq_a;
    dq_flag_next        = dq_a;
    tokens_emitted_next = cnt_a + LW'(b_req && !b_refused);
    if (b_run_fresh) begin
      mode_next     = f_mode;
      has_text_next = text_a | f_text;
      sq_flag_next  = sq_a | f_sq;
      dq_flag_next  = dq_a | f_dq;
    end
    if (a_refused || b_refused) begin
      mode_next = MODE_DISCARD;
    end
    if (end_of_input) begin
      mode_next           = MODE_IDLE;
      has_text_next       = 1'b0;
      sq_flag_next        = 1'b0;
      dq_flag_next        = 1'b0;
      tokens_emitted_next = '0;
    end
  end

  // Results
  always_comb begin
    a_any = a_put || a_req;
    b_any = b_put || b_req;
    if (a_put) begin
      ra = '{kind: a_put_kind, data: a_put_data, sq: 1'b0, dq: 1'b0,
             err: a_put_err, last: 1'b0};
    end else begin
      ra = '{kind: a_kind, data: 8'h00, sq: a_sq, dq: a_dq,
             err: a_refused ? ERR_EXHAUSTED : ERR_NONE, last: 1'b0};
    end
    if (b_put) begin
      rb = '{kind: KIND_BYTE, data: char_in, sq: 1'b0, dq: 1'b0,
             err: ERR_NONE, last: 1'b1};
    end else begin
      rb = '{kind: b_kind, data: 8'h00, sq: 1'b0, dq: 1'b0,
             err: b_refused ? ERR_EXHAUSTED : ERR_NONE, last: 1'b1};
    end
    ra.last     = !b_any;
    push.first  = a_any ? ra : rb;
    push.second = rb;
    push.count  = accept ? ({1'b0, a_any} + {1'b0, b_any}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      has_text       <= 1'b0;
      sq_flag        <= 1'b0;
      dq_flag        <= 1'b0;
      tokens_emitted <= '0;
    end else if (accept) begin
      mode           <= mode_next;
      has_text       <= has_text_next;
      sq_flag        <= sq_flag_next;
      dq_flag        <= dq_flag_next;
      tokens_emitted <= tokens_emitted_next;
    end
  end

endmodule

/* rtl/slc_result_fifo.sv */
// slc_result_fifo: small result queue taking up to two results per cycle
// and handing out one per output transaction. Depends on slc_pkg.
module slc_result_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  slc_pkg::result_pair_t  push,
  output logic                   space_ok,
  output logic                   out_valid,
  input  logic                   out_ready,
  output slc_pkg::result_t       head
);
  import slc_pkg::*;

  result_t                 mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [FIFO_CNT_W-1:0]   count, count_next;
  logic                    pop;

  // Room for the worst case of two results
  assign space_ok  = count <= FIFO_CNT_W'(FIFO_DEPTH - 2);
  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign head      = mem[rd_ptr];
  assign count_next = count + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + FIFO_PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push.count);
      rd_ptr <= rd_ptr + FIFO_PTR_W'(pop);
      count  <= count_next;
    end
  end

endmodule

/* rtl/slc_checker.sv */
// slc_checker: port-level checks for shell_command_lexer, attached by bind.
// Depends on slc_pkg.
module slc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] token_kind,
  input logic [7:0] word_byte,
  input logic       single_quoted,
  input logic       double_quoted,
  input logic [1:0] error_code,
  input logic       last_of_run
);
  import slc_pkg::*;

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({token_kind, word_byte, error_code, last_of_run}))
    else $error("result changed while stalled");

  a_byte_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == KIND_BYTE |->
      error_code == ERR_NONE && !single_quoted && !double_quoted)
    else $error("word byte carries flags or error");

  // Nothing follows an error within one input transaction
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_NONE |-> last_of_run)
    else $error("error result not last of run");

  a_quote_err_eof: assert property (@(posedge clk) disable iff (rst)
    out_valid && (error_code == ERR_OPEN_SINGLE || error_code == ERR_OPEN_DOUBLE)
      |-> token_kind == KIND_EOF && last_of_run)
    else $error("unterminated quote error not on end of file");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("queue not empty after reset");

endmodule

bind shell_command_lexer slc_checker u_slc_checker (.*);
